>>> rtl/keypad_code_lock_controller_core_defines.svh
// ----------------------------------------------------------------------------
// keypad code lock controller assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_CORE_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define KCLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define KCLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/kclc_pkg.sv
// ----------------------------------------------------------------------------
// kclc_pkg
// shared constants, result kinds and helper functions of the code lock
// ----------------------------------------------------------------------------
`default_nettype none
package kclc_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int LOG_DEPTH   = 64;
  localparam int PRESET_NUM  = 10;

  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int TCW = $clog2(TABLE_DEPTH + 1);
  localparam int LAW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LCW = $clog2(LOG_DEPTH + 1);
  localparam int LOG_W = 33;

  localparam logic [TCW-1:0] TABLE_FULL = TCW'(TABLE_DEPTH);
  localparam logic [TCW-1:0] PRESET_CNT = TCW'(PRESET_NUM);
  localparam logic [LCW-1:0] LOG_FULL   = LCW'(LOG_DEPTH);

  localparam logic [2:0] KIND_TIME     = 3'd0;
  localparam logic [2:0] KIND_ENTRY    = 3'd1;
  localparam logic [2:0] KIND_GRANTED  = 3'd2;
  localparam logic [2:0] KIND_DENIED   = 3'd3;
  localparam logic [2:0] KIND_ADDED    = 3'd4;
  localparam logic [2:0] KIND_REJECTED = 3'd5;
  localparam logic [2:0] KIND_LOGENTRY = 3'd6;
  localparam logic [2:0] KIND_REFUSED  = 3'd7;

  localparam logic [3:0] KEY_STAR = 4'd10;
  localparam logic [3:0] KEY_HASH = 4'd11;
  localparam logic [3:0] KEY_HASH_DIGIT = 4'd3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_PRESS = 1'b1;

  localparam logic       CFG_LOG_CMD  = 1'b0;
  localparam logic       CFG_LOG_AUTH = 1'b1;
  localparam logic [15:0] LOG_CMD_RST  = 16'h9999;
  localparam logic [15:0] LOG_AUTH_RST = 16'h1111;

  function automatic logic [15:0] preset_code(input logic [3:0] i);
    logic [15:0] c;
    case (i)
      4'd0:    c = 16'h2332;
      4'd1:    c = 16'h1111;
      4'd2:    c = 16'h3333;
      4'd3:    c = 16'h9369;
      4'd4:    c = 16'h6363;
      4'd5:    c = 16'h7777;
      4'd6:    c = 16'h1793;
      4'd7:    c = 16'h5525;
      4'd8:    c = 16'h4100;
      4'd9:    c = 16'h1010;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  // two-digit bcd of a value below 64
  function automatic logic [7:0] to_bcd(input logic [5:0] v);
    logic [3:0] t;
    logic [5:0] r;
    if (v >= 6'd60) begin
      t = 4'd6; r = v - 6'd60;
    end else if (v >= 6'd50) begin
      t = 4'd5; r = v - 6'd50;
    end else if (v >= 6'd40) begin
      t = 4'd4; r = v - 6'd40;
    end else if (v >= 6'd30) begin
      t = 4'd3; r = v - 6'd30;
    end else if (v >= 6'd20) begin
      t = 4'd2; r = v - 6'd20;
    end else if (v >= 6'd10) begin
      t = 4'd1; r = v - 6'd10;
    end else begin
      t = 4'd0; r = v;
    end
    return {t, r[3:0]};
  endfunction

endpackage
`default_nettype wire

>>> rtl/kclc_code_store.sv
// ----------------------------------------------------------------------------
// kclc_code_store
// password table memory; the preset slots come from constants
// ----------------------------------------------------------------------------
`default_nettype none
module kclc_code_store (
  input  wire logic                     clk,
  input  wire logic [kclc_pkg::TAW-1:0] rd_idx,
  input  wire logic                     wr_en,
  input  wire logic [kclc_pkg::TAW-1:0] wr_idx,
  input  wire logic [15:0]              wr_data,
  output logic      [15:0]              rd_data
);

  logic [15:0] mem [kclc_pkg::TABLE_DEPTH];
  logic [15:0] mem_q_r;
  logic [15:0] pre_val_r;
  logic        pre_sel_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    mem_q_r   <= mem[rd_idx];
    pre_sel_r <= (rd_idx < kclc_pkg::TAW'(kclc_pkg::PRESET_NUM));
    pre_val_r <= kclc_pkg::preset_code(rd_idx[3:0]);
  end

  // preset slots are never written, they read from the constant table
  assign rd_data = pre_sel_r ? pre_val_r : mem_q_r;

endmodule
`default_nettype wire

>>> rtl/kclc_log_store.sv
// ----------------------------------------------------------------------------
// kclc_log_store
// access log memory holding hour, minute, second and code per grant
// ----------------------------------------------------------------------------
`default_nettype none
module kclc_log_store (
  input  wire logic                       clk,
  input  wire logic [kclc_pkg::LAW-1:0]   rd_idx,
  input  wire logic                       wr_en,
  input  wire logic [kclc_pkg::LAW-1:0]   wr_idx,
  input  wire logic [kclc_pkg::LOG_W-1:0] wr_data,
  output logic      [kclc_pkg::LOG_W-1:0] rd_data
);

  logic [kclc_pkg::LOG_W-1:0] mem [kclc_pkg::LOG_DEPTH];
  logic [kclc_pkg::LOG_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> rtl/keypad_code_lock_controller_core.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_core
// keypad code lock with 24-hour clock, password table and access log
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall) carries a tick (in_opcode 0) or a key
//   press (in_opcode 1, in_key_code). result channel (out_valid/out_stall)
//   carries at most one result per transaction, or a run of log entries on playback;
//   out_last_of_run marks the final result of a transaction.
//   ticks, digit keys and a '#' outside entry are handled in idle; the result
//   is registered and shows the cycle after acceptance. undefined keys give
//   no result. '#' during entry (unless it is the log command code) and '*'
//   walk the password table through its memory port, a read state and a
//   compare state per stored code. a log playback first checks the newest
//   log entry against the authorizer code, then reads and outputs each entry.
//   only one transaction is in work at a time; in_stall is high while it runs
//   or while an undelivered result sits in the output register.
//   when the receiver stalls the output register holds its result and the
//   block waits; no result is dropped.
//   reset (rst_n low, synchronous) clears the clock, entry and log count,
//   presets the code count and default log codes; memories need no clearing.
//   cfg_we writes the log command (index 0) or authorizer (index 1) code.
// ----------------------------------------------------------------------------
`default_nettype none
module keypad_code_lock_controller_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [3:0]  in_key_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [4:0]       out_hour_value,
  output logic [5:0]       out_minute_value,
  output logic [5:0]       out_second_value,
  output logic [15:0]      out_code_value,
  output logic [6:0]       out_log_position,
  output logic             out_last_of_run,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_LCHK, S_LCHK_CMP, S_PLAY_RD, S_PLAY_OUT
  } state_t;

  localparam int TCW = kclc_pkg::TCW;
  localparam int TAW = kclc_pkg::TAW;
  localparam int LCW = kclc_pkg::LCW;
  localparam int LAW = kclc_pkg::LAW;

  state_t         state_r, state_nxt;
  logic [15:0]    cmd_code_r, cmd_code_nxt;
  logic [15:0]    auth_code_r, auth_code_nxt;
  logic [15:0]    entry_r, entry_nxt;
  logic           entering_r, entering_nxt;
  logic [TCW-1:0] code_cnt_r, code_cnt_nxt;
  logic [LCW-1:0] log_cnt_r, log_cnt_nxt;
  logic [4:0]     hh_r, hh_nxt;
  logic [5:0]     mm_r, mm_nxt;
  logic [5:0]     ss_r, ss_nxt;
  logic [15:0]    code_r, code_nxt;
  logic           is_star_r, is_star_nxt;
  logic [TCW-1:0] idx_r, idx_nxt;
  logic [LCW-1:0] pidx_r, pidx_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [2:0]     kind_r, kind_nxt;
  logic [4:0]     ohh_r, ohh_nxt;
  logic [5:0]     omm_r, omm_nxt;
  logic [5:0]     oss_r, oss_nxt;
  logic [15:0]    ocode_r, ocode_nxt;
  logic [6:0]     opos_r, opos_nxt;
  logic           olast_r, olast_nxt;

  logic           out_free;
  logic           in_acc;
  logic [15:0]    tbl_rd_data;
  logic           tbl_we;
  logic [kclc_pkg::LOG_W-1:0] log_rd_data;
  logic           log_we;
  logic [LAW-1:0] log_rd_idx;
  logic [LCW-1:0] log_last;

  logic [4:0]     t_hh;
  logic [5:0]     t_mm;
  logic [5:0]     t_ss;
  logic [15:0]    idle_now;
  logic [15:0]    idle_tick;
  logic [15:0]    shifted;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign log_last = log_cnt_r - LCW'(1);

  // clock after a tick
  always_comb begin
    t_hh = hh_r;
    t_mm = mm_r;
    t_ss = ss_r;
    if (ss_r < 6'd59) begin
      t_ss = ss_r + 6'd1;
    end else begin
      t_ss = 6'd0;
      if (mm_r < 6'd59) begin
        t_mm = mm_r + 6'd1;
      end else begin
        t_mm = 6'd0;
        t_hh = (hh_r < 5'd23) ? hh_r + 5'd1 : 5'd0;
      end
    end
  end

  assign idle_now  = entering_r ? entry_r
                                : {kclc_pkg::to_bcd(mm_r), kclc_pkg::to_bcd(ss_r)};
  assign idle_tick = entering_r ? entry_r
                                : {kclc_pkg::to_bcd(t_mm), kclc_pkg::to_bcd(t_ss)};
  assign shifted   = {(entering_r ? entry_r[11:0] : 12'h000),
                      (in_key_code == kclc_pkg::KEY_HASH) ? kclc_pkg::KEY_HASH_DIGIT
                                                          : in_key_code};

  assign log_rd_idx = (state_r == S_LCHK) ? log_last[LAW-1:0] : pidx_r[LAW-1:0];

  always_comb begin
    state_nxt     = state_r;
    cmd_code_nxt  = cmd_code_r;
    auth_code_nxt = auth_code_r;
    entry_nxt     = entry_r;
    entering_nxt  = entering_r;
    code_cnt_nxt  = code_cnt_r;
    log_cnt_nxt   = log_cnt_r;
    hh_nxt        = hh_r;
    mm_nxt        = mm_r;
    ss_nxt        = ss_r;
    code_nxt      = code_r;
    is_star_nxt   = is_star_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    ohh_nxt       = ohh_r;
    omm_nxt       = omm_r;
    oss_nxt       = oss_r;
    ocode_nxt     = ocode_r;
    opos_nxt      = opos_r;
    olast_nxt     = olast_r;
    tbl_we        = 1'b0;
    log_we        = 1'b0;

    if (cfg_we) begin
      if (cfg_index == kclc_pkg::CFG_LOG_CMD) begin
        cmd_code_nxt = cfg_wdata;
      end else begin
        auth_code_nxt = cfg_wdata;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ohh_nxt   = hh_r;
          omm_nxt   = mm_r;
          oss_nxt   = ss_r;
          opos_nxt  = 7'd0;
          olast_nxt = 1'b1;
          if (in_opcode == kclc_pkg::OP_TICK) begin
            hh_nxt        = t_hh;
            mm_nxt        = t_mm;
            ss_nxt        = t_ss;
            ohh_nxt       = t_hh;
            omm_nxt       = t_mm;
            oss_nxt       = t_ss;
            kind_nxt      = kclc_pkg::KIND_TIME;
            ocode_nxt     = idle_tick;
            out_valid_nxt = 1'b1;
          end else if (in_key_code == kclc_pkg::KEY_HASH && entering_r) begin
            entering_nxt = 1'b0;
            code_nxt     = entry_r;
            is_star_nxt  = 1'b0;
            idx_nxt      = '0;
            if (entry_r == cmd_code_r) begin
              if (log_cnt_r > LCW'(1)) begin
                state_nxt = S_LCHK;
              end else begin
                kind_nxt      = kclc_pkg::KIND_REFUSED;
                ocode_nxt     = entry_r;
                out_valid_nxt = 1'b1;
              end
            end else begin
              state_nxt = S_SRCH_RD;
            end
          end else if (in_key_code == kclc_pkg::KEY_STAR) begin
            entering_nxt = 1'b0;
            code_nxt     = idle_now;
            is_star_nxt  = 1'b1;
            idx_nxt      = '0;
            state_nxt    = S_SRCH_RD;
          end else if (in_key_code <= kclc_pkg::KEY_HASH) begin
            entering_nxt  = 1'b1;
            entry_nxt     = shifted;
            kind_nxt      = kclc_pkg::KIND_ENTRY;
            ocode_nxt     = shifted;
            out_valid_nxt = 1'b1;
          end
        end
      end

      S_SRCH_RD, S_SRCH_CMP: begin
        if (state_r == S_SRCH_CMP && tbl_rd_data != code_r) begin
          idx_nxt   = idx_r + TCW'(1);
          state_nxt = S_SRCH_RD;
        end else if (state_r == S_SRCH_CMP || idx_r >= code_cnt_r) begin
          // search done: hit when the compare matched
          ohh_nxt       = hh_r;
          omm_nxt       = mm_r;
          oss_nxt       = ss_r;
          ocode_nxt     = code_r;
          opos_nxt      = 7'd0;
          olast_nxt     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (is_star_r) begin
            if (state_r == S_SRCH_CMP || code_cnt_r >= kclc_pkg::TABLE_FULL) begin
              kind_nxt = kclc_pkg::KIND_REJECTED;
            end else begin
              kind_nxt     = kclc_pkg::KIND_ADDED;
              tbl_we       = 1'b1;
              code_cnt_nxt = code_cnt_r + TCW'(1);
            end
          end else if (state_r == S_SRCH_CMP) begin
            kind_nxt = kclc_pkg::KIND_GRANTED;
            if (log_cnt_r < kclc_pkg::LOG_FULL) begin
              log_we      = 1'b1;
              log_cnt_nxt = log_cnt_r + LCW'(1);
            end
          end else begin
            kind_nxt = kclc_pkg::KIND_DENIED;
          end
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end

      S_LCHK: begin
        state_nxt = S_LCHK_CMP;
      end

      S_LCHK_CMP: begin
        if (log_rd_data[15:0] == auth_code_r) begin
          pidx_nxt  = '0;
          state_nxt = S_PLAY_RD;
        end else begin
          kind_nxt      = kclc_pkg::KIND_REFUSED;
          ohh_nxt       = hh_r;
          omm_nxt       = mm_r;
          oss_nxt       = ss_r;
          ocode_nxt     = code_r;
          opos_nxt      = 7'd0;
          olast_nxt     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_PLAY_RD: begin
        state_nxt = S_PLAY_OUT;
      end

      S_PLAY_OUT: begin
        if (out_free) begin
          kind_nxt      = kclc_pkg::KIND_LOGENTRY;
          ohh_nxt       = log_rd_data[32:28];
          omm_nxt       = log_rd_data[27:22];
          oss_nxt       = log_rd_data[21:16];
          ocode_nxt     = log_rd_data[15:0];
          opos_nxt      = 7'(pidx_r + LCW'(1));
          olast_nxt     = (pidx_r == log_last);
          out_valid_nxt = 1'b1;
          pidx_nxt      = pidx_r + LCW'(1);
          state_nxt     = (pidx_r == log_last) ? S_IDLE : S_PLAY_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_code_r  <= kclc_pkg::LOG_CMD_RST;
      auth_code_r <= kclc_pkg::LOG_AUTH_RST;
      entry_r     <= 16'h0000;
      entering_r  <= 1'b0;
      code_cnt_r  <= kclc_pkg::PRESET_CNT;
      log_cnt_r   <= '0;
      hh_r        <= 5'd0;
      mm_r        <= 6'd0;
      ss_r        <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_code_r  <= cmd_code_nxt;
      auth_code_r <= auth_code_nxt;
      entry_r     <= entry_nxt;
      entering_r  <= entering_nxt;
      code_cnt_r  <= code_cnt_nxt;
      log_cnt_r   <= log_cnt_nxt;
      hh_r        <= hh_nxt;
      mm_r        <= mm_nxt;
      ss_r        <= ss_nxt;
      out_valid_r <= out_valid_nxt;
    end
    code_r    <= code_nxt;
    is_star_r <= is_star_nxt;
    idx_r     <= idx_nxt;
    pidx_r    <= pidx_nxt;
    kind_r    <= kind_nxt;
    ohh_r     <= ohh_nxt;
    omm_r     <= omm_nxt;
    oss_r     <= oss_nxt;
    ocode_r   <= ocode_nxt;
    opos_r    <= opos_nxt;
    olast_r   <= olast_nxt;
  end

  kclc_code_store u_code_store (
    .clk     (clk),
    .rd_idx  (idx_r[TAW-1:0]),
    .wr_en   (tbl_we),
    .wr_idx  (code_cnt_r[TAW-1:0]),
    .wr_data (code_r),
    .rd_data (tbl_rd_data)
  );

  kclc_log_store u_log_store (
    .clk     (clk),
    .rd_idx  (log_rd_idx),
    .wr_en   (log_we),
    .wr_idx  (log_cnt_r[LAW-1:0]),
    .wr_data ({hh_r, mm_r, ss_r, code_r}),
    .rd_data (log_rd_data)
  );

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_hour_value   = ohh_r;
  assign out_minute_value = omm_r;
  assign out_second_value = oss_r;
  assign out_code_value   = ocode_r;
  assign out_log_position = opos_r;
  assign out_last_of_run  = olast_r;

endmodule
`default_nettype wire

>>> rtl/kclc_checker.sv
// ----------------------------------------------------------------------------
// kclc_checker
// port-level checks of the code lock result channel
// ----------------------------------------------------------------------------
`default_nettype none
`include "keypad_code_lock_controller_core_defines.svh"
module kclc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_kind,
  input wire logic [4:0]  out_hour_value,
  input wire logic [5:0]  out_minute_value,
  input wire logic [5:0]  out_second_value,
  input wire logic [15:0] out_code_value,
  input wire logic [6:0]  out_log_position,
  input wire logic        out_last_of_run
);

  `KCLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_code_value) && $stable(out_log_position), "stalled result changed")
  `KCLC_ASSERT_NOW(a_pos_kind, out_valid, (out_kind == kclc_pkg::KIND_LOGENTRY) == (out_log_position != 7'd0), "log position does not match kind")
  `KCLC_ASSERT_NOW(a_single_last, out_valid && out_kind != kclc_pkg::KIND_LOGENTRY, out_last_of_run, "single result not marked last")
  `KCLC_ASSERT_NOW(a_time_range, out_valid && out_kind == kclc_pkg::KIND_TIME, out_hour_value < 5'd24 && out_minute_value < 6'd60 && out_second_value < 6'd60, "clock out of range")

endmodule

bind keypad_code_lock_controller_core kclc_checker u_kclc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_hour_value   (out_hour_value),
  .out_minute_value (out_minute_value),
  .out_second_value (out_second_value),
  .out_code_value   (out_code_value),
  .out_log_position (out_log_position),
  .out_last_of_run  (out_last_of_run)
);
`default_nettype wire
